### hw/rtl/tjt_pkg.sv
// ----------------------------------------------------------------------------
// tjt_pkg
// Types, codes and helper functions shared by the timeout job table.
// ----------------------------------------------------------------------------
package tjt_pkg;

    localparam logic [1:0] FUNC_SCHEDULE = 2'd0;
    localparam logic [1:0] FUNC_RUN      = 2'd1;
    localparam logic [1:0] FUNC_CLEAR    = 2'd2;

    localparam int          TICKS_W     = 20;
    localparam logic [19:0] TICKS_RESET = 20'd19200;
    localparam int          PADDR_W     = 3;
    localparam logic [2:0]  ADDR_TICKS  = 3'd0;
    localparam int          MASK_W      = 16;

    typedef logic [1:0]        func_t;
    typedef logic [31:0]       time_t;
    typedef logic [MASK_W-1:0] mask_t;

    typedef struct packed {
        time_t start;
        time_t deadline;
        logic  has_alt;
    } entry_t;

    // A slot expires once now has reached the deadline, unless the deadline
    // wrapped past zero and now has not yet wrapped with it.
    function automatic logic expired(time_t now, time_t start, time_t dl);
        logic res;
        if (now < dl) begin
            res = 1'b0;
        end else if (start <= dl) begin
            res = 1'b1;
        end else begin
            res = (now < start);
        end
        return res;
    endfunction

endpackage

### hw/rtl/timeout_job_table_top.sv
// ----------------------------------------------------------------------------
// timeout_job_table_top
// A table of one-shot timeout slots kept in a synchronous memory.
//
// Items arrive on the s_ channel (valid/ready) and each one gives exactly one
// result on the m_ channel. A schedule item takes the lowest free slot and
// stores its start time, deadline and early-exit flag; it passes through the
// registered deadline multiply and then the memory write. A run item reads
// the slot memory one entry per cycle through its single read port. A clear
// item or an unused code goes straight to the done state. One item is worked
// on at a time; s_ready is high whenever the engine is idle.
// Results wait in an output register, so a new item may be accepted while
// the previous result is still stalled by the receiver; the engine then
// holds its finished result until the output register frees.
// Reset clears all valid bits, the control state and the output register,
// and sets ticks_per_ms to 19200. No clearing pass over the memory is
// needed. ticks_per_ms is written through the APB port at address 0.
// ----------------------------------------------------------------------------
module timeout_job_table_top #(
    parameter int SLOTS = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  tjt_pkg::func_t            s_func,
    input  tjt_pkg::time_t            s_now,
    input  logic [31:0]               s_delay_ms,
    input  logic                      s_has_alternative,
    input  tjt_pkg::mask_t            s_alt_flags,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_granted,
    output logic [3:0]                m_slot,
    output tjt_pkg::mask_t            m_fired_mask,
    output tjt_pkg::mask_t            m_alt_mask,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [tjt_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);
    import tjt_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL   = 3'd1;
    localparam logic [2:0] ST_WRITE = 3'd2;
    localparam logic [2:0] ST_SCAN  = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]         state_reg, state_next;
    logic [SLOTS-1:0]   valid_reg, valid_next;
    logic [TICKS_W-1:0] ticks_reg;

    func_t              func_reg;
    time_t              now_reg;
    logic [31:0]        delay_reg;
    logic               has_alt_reg;
    mask_t              alt_flags_reg;
    time_t              prod_reg, prod_next;
    logic [51:0]        prod_full;

    logic               granted_reg, granted_next;
    logic [3:0]         slot_reg, slot_next;
    mask_t              fired_reg, fired_next;
    mask_t              altm_reg, altm_next;

    logic [CNT_W-1:0]   rd_cnt_reg, rd_cnt_next;
    logic               eval_vld_reg, eval_vld_next;
    logic [IDX_W-1:0]   eval_idx_reg, eval_idx_next;

    entry_t             mem [SLOTS];
    entry_t             rd_data_reg;
    entry_t             wr_data;
    logic               rd_en, wr_en;
    logic [IDX_W-1:0]   rd_addr;

    logic               free_found;
    logic [IDX_W-1:0]   free_idx;
    mask_t              eval_bit;
    logic               in_acc, out_free, cfg_wr;

    logic               m_valid_reg;
    logic               m_granted_reg;
    logic [3:0]         m_slot_reg;
    mask_t              m_fired_reg, m_alt_reg;

    assign in_acc   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign pready   = 1'b1;
    assign prdata   = (paddr == ADDR_TICKS) ? 32'(ticks_reg) : 32'd0;

    assign prod_full = 52'(delay_reg) * 52'(ticks_reg);
    assign wr_data   = '{start: now_reg, deadline: now_reg + prod_reg,
                         has_alt: has_alt_reg};

    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    always_comb begin
        for (int j = 0; j < MASK_W; j++) begin
            eval_bit[j] = (32'(eval_idx_reg) == 32'(j));
        end
    end

    always_comb begin
        state_next    = state_reg;
        valid_next    = valid_reg;
        prod_next     = prod_reg;
        granted_next  = granted_reg;
        slot_next     = slot_reg;
        fired_next    = fired_reg;
        altm_next     = altm_reg;
        rd_cnt_next   = rd_cnt_reg;
        eval_vld_next = 1'b0;
        eval_idx_next = eval_idx_reg;
        rd_en         = 1'b0;
        rd_addr       = rd_cnt_reg[IDX_W-1:0];
        wr_en         = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    granted_next = 1'b0;
                    slot_next    = '0;
                    fired_next   = '0;
                    altm_next    = '0;
                    rd_cnt_next  = '0;
                    unique case (s_func)
                        FUNC_SCHEDULE: state_next = ST_MUL;
                        FUNC_RUN:      state_next = ST_SCAN;
                        FUNC_CLEAR: begin
                            valid_next = '0;
                            state_next = ST_DONE;
                        end
                        default:       state_next = ST_DONE;
                    endcase
                end
            end
            ST_MUL: begin
                prod_next  = prod_full[31:0];
                state_next = ST_WRITE;
            end
            ST_WRITE: begin
                if (free_found) begin
                    wr_en                = 1'b1;
                    valid_next[free_idx] = 1'b1;
                    granted_next         = 1'b1;
                    slot_next            = 4'(free_idx);
                end
                state_next = ST_DONE;
            end
            ST_SCAN: begin
                if (rd_cnt_reg < CNT_W'(SLOTS)) begin
                    rd_en         = 1'b1;
                    eval_vld_next = 1'b1;
                    eval_idx_next = rd_cnt_reg[IDX_W-1:0];
                    rd_cnt_next   = rd_cnt_reg + CNT_W'(1);
                end
                if (eval_vld_reg) begin
                    if (valid_reg[eval_idx_reg]) begin
                        if (expired(now_reg, rd_data_reg.start, rd_data_reg.deadline)) begin
                            valid_next[eval_idx_reg] = 1'b0;
                            fired_next = fired_reg | eval_bit;
                        end else if (rd_data_reg.has_alt && |(alt_flags_reg & eval_bit)) begin
                            valid_next[eval_idx_reg] = 1'b0;
                            altm_next = altm_reg | eval_bit;
                        end
                    end
                    if (eval_idx_reg == LAST_IDX) begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            valid_reg    <= '0;
            ticks_reg    <= TICKS_RESET;
            eval_vld_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            valid_reg    <= valid_next;
            eval_vld_reg <= eval_vld_next;
            if (cfg_wr && paddr == ADDR_TICKS) begin
                ticks_reg <= pwdata[TICKS_W-1:0];
            end
            if (state_reg == ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            func_reg      <= s_func;
            now_reg       <= s_now;
            delay_reg     <= s_delay_ms;
            has_alt_reg   <= s_has_alternative;
            alt_flags_reg <= s_alt_flags;
        end
        prod_reg     <= prod_next;
        granted_reg  <= granted_next;
        slot_reg     <= slot_next;
        fired_reg    <= fired_next;
        altm_reg     <= altm_next;
        rd_cnt_reg   <= rd_cnt_next;
        eval_idx_reg <= eval_idx_next;
        if (state_reg == ST_DONE && out_free) begin
            m_granted_reg <= granted_reg;
            m_slot_reg    <= slot_reg;
            m_fired_reg   <= fired_reg;
            m_alt_reg     <= altm_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[free_idx] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_granted    = m_granted_reg;
    assign m_slot       = m_slot_reg;
    assign m_fired_mask = m_fired_reg;
    assign m_alt_mask   = m_alt_reg;

    a_masks_disjoint: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_fired_mask & m_alt_mask) == '0)
        else $error("A slot is reported both fired and freed early.");

    a_slot_zero_unless_granted: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_granted) |-> m_slot == 4'd0)
        else $error("A slot index is reported without a grant.");

    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && s_func == FUNC_CLEAR) |=> valid_reg == '0)
        else $error("A clear item left slots in use.");

    a_grant_takes_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WRITE && free_found) |=>
            $countones(valid_reg) == $past($countones(valid_reg)) + 1)
        else $error("A granted schedule did not occupy exactly one slot.");

    a_scan_only_frees: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |=> (valid_reg & ~$past(valid_reg)) == '0)
        else $error("A run check marked a slot as in use.");

    a_func_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> func_reg == FUNC_RUN)
        else $error("The scan runs for an item that is not a run check.");

endmodule

### test/timeout_job_table_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timeout_job_table_top_tb
// Drives the timeout job table with a table of directed items and then with
// random schedule, run and clear sequences under several tick rates. Each
// result is typed in or predicted from a model of the slot table and checked
// field by field, with random gaps on the input and stalls on the output.
// ----------------------------------------------------------------------------
module timeout_job_table_top_tb;
    import tjt_pkg::*;

    localparam func_t FUNC_UNUSED     = 2'd3;
    localparam int    NUM_SLOTS       = 16;
    localparam int    RANDOM_PHASES   = 5;
    localparam int    ITEMS_PER_PHASE = 190;
    localparam int    DIR_ROWS        = 20;
    localparam int    DRAIN_CYCLES    = 40;

    typedef struct packed {
        func_t       func;
        time_t       now;
        logic [31:0] delay_ms;
        logic        has_alt;
        mask_t       alt_flags;
    } job_item_t;

    typedef struct packed {
        logic       granted;
        logic [3:0] slot;
        mask_t      fired;
        mask_t      alt;
    } job_result_t;

    typedef struct packed {
        func_t       func;
        time_t       now;
        logic [31:0] delay_ms;
        logic        has_alt;
        mask_t       alt_flags;
        logic [4:0]  reps;
        logic        known;
        logic        granted;
        logic [3:0]  slot;
        mask_t       fired;
        mask_t       alt;
    } dir_row_t;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    func_t               s_func;
    time_t               s_now;
    logic [31:0]         s_delay_ms;
    logic                s_has_alternative;
    mask_t               s_alt_flags;
    logic                m_valid;
    logic                m_ready;
    logic                m_granted;
    logic [3:0]          m_slot;
    mask_t               m_fired_mask;
    mask_t               m_alt_mask;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    logic [TICKS_W-1:0]  ticks_setting;
    logic [NUM_SLOTS-1:0] table_valid;
    time_t               table_start [NUM_SLOTS];
    time_t               table_deadline [NUM_SLOTS];
    logic                table_alt [NUM_SLOTS];
    job_result_t         pending_results [$];
    time_t               cur_time;
    logic                no_idle;
    int                  mismatches = 0;

    dir_row_t dir_table [DIR_ROWS] = '{
        '{FUNC_RUN,      32'd0,         32'd0,         1'b0, 16'h0000, 5'd1,  1'b1,
          1'b0, 4'd0, 16'h0000, 16'h0000},
        '{FUNC_UNUSED,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, 5'd1,  1'b1,
          1'b0, 4'd0, 16'h0000, 16'h0000},
        '{FUNC_SCHEDULE, 32'd100,       32'd0,         1'b0, 16'h0000, 5'd1,  1'b1,
          1'b1, 4'd0, 16'h0000, 16'h0000},
        '{FUNC_RUN,      32'd99,        32'd0,         1'b0, 16'hFFFF, 5'd1,  1'b1,
          1'b0, 4'd0, 16'h0000, 16'h0000},
        '{FUNC_RUN,      32'd100,       32'd0,         1'b0, 16'h0000, 5'd1,  1'b1,
          1'b0, 4'd0, 16'h0001, 16'h0000},
        '{FUNC_SCHEDULE, 32'hFFFF_FF00, 32'd1,         1'b1, 16'h0000, 5'd1,  1'b1,
          1'b1, 4'd0, 16'h0000, 16'h0000},
        '{FUNC_SCHEDULE, 32'd0,         32'hFFFF_FFFF, 1'b0, 16'h0000, 5'd1,  1'b1,
          1'b1, 4'd1, 16'h0000, 16'h0000},
        '{FUNC_RUN,      32'h0000_49FF, 32'd0,         1'b0, 16'h0000, 5'd1,  1'b1,
          1'b0, 4'd0, 16'h0000, 16'h0000},
        '{FUNC_RUN,      32'h0000_4A00, 32'd0,         1'b0, 16'h0000, 5'd1,  1'b1,
          1'b0, 4'd0, 16'h0001, 16'h0000},
        '{FUNC_SCHEDULE, 32'hFFFF_FFF0, 32'd1,         1'b1, 16'h0000, 5'd1,  1'b1,
          1'b1, 4'd0, 16'h0000, 16'h0000},
        '{FUNC_RUN,      32'hFFFF_FFFF, 32'd0,         1'b0, 16'h0001, 5'd1,  1'b1,
          1'b0, 4'd0, 16'h0002, 16'h0001},
        '{FUNC_SCHEDULE, 32'd1000,      32'd2,         1'b1, 16'h0000, 5'd16, 1'b0,
          1'b0, 4'd0, 16'h0000, 16'h0000},
        '{FUNC_SCHEDULE, 32'd5000,      32'd3,         1'b0, 16'h0000, 5'd1,  1'b1,
          1'b0, 4'd0, 16'h0000, 16'h0000},
        '{FUNC_RUN,      32'd1000,      32'd0,         1'b0, 16'hAAAA, 5'd1,  1'b1,
          1'b0, 4'd0, 16'h0000, 16'hAAAA},
        '{FUNC_RUN,      32'd39400,     32'd0,         1'b0, 16'h0000, 5'd1,  1'b1,
          1'b0, 4'd0, 16'h5555, 16'h0000},
        '{FUNC_SCHEDULE, 32'd7,         32'd0,         1'b1, 16'h0000, 5'd1,  1'b1,
          1'b1, 4'd0, 16'h0000, 16'h0000},
        '{FUNC_CLEAR,    32'd7,         32'd7,         1'b1, 16'hFFFF, 5'd1,  1'b1,
          1'b0, 4'd0, 16'h0000, 16'h0000},
        '{FUNC_SCHEDULE, 32'd5,         32'd0,         1'b1, 16'h0000, 5'd1,  1'b1,
          1'b1, 4'd0, 16'h0000, 16'h0000},
        '{FUNC_UNUSED,   32'd5,         32'd5,         1'b1, 16'hFFFF, 5'd1,  1'b1,
          1'b0, 4'd0, 16'h0000, 16'h0000},
        '{FUNC_RUN,      32'd0,         32'd0,         1'b0, 16'hFFFF, 5'd1,  1'b1,
          1'b0, 4'd0, 16'h0000, 16'h0001}
    };

    timeout_job_table_top i_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_func            (s_func),
        .s_now             (s_now),
        .s_delay_ms        (s_delay_ms),
        .s_has_alternative (s_has_alternative),
        .s_alt_flags       (s_alt_flags),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_granted         (m_granted),
        .m_slot            (m_slot),
        .m_fired_mask      (m_fired_mask),
        .m_alt_mask        (m_alt_mask),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic logic deadline_passed(time_t now, time_t start, time_t dl);
        return (now >= dl) && ((start <= dl) || (now < start));
    endfunction

    function automatic job_result_t predict_job(job_item_t it);
        job_result_t res;
        res = '0;
        case (it.func)
            FUNC_SCHEDULE: begin
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (!res.granted && !table_valid[i]) begin
                        table_valid[i]    = 1'b1;
                        table_start[i]    = it.now;
                        table_deadline[i] = it.now + it.delay_ms * {12'd0, ticks_setting};
                        table_alt[i]      = it.has_alt;
                        res.granted       = 1'b1;
                        res.slot          = 4'(i);
                    end
                end
            end
            FUNC_RUN: begin
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (table_valid[i]) begin
                        if (deadline_passed(it.now, table_start[i], table_deadline[i])) begin
                            table_valid[i] = 1'b0;
                            res.fired[i]   = 1'b1;
                        end else if (table_alt[i] && it.alt_flags[i]) begin
                            table_valid[i] = 1'b0;
                            res.alt[i]     = 1'b1;
                        end
                    end
                end
            end
            FUNC_CLEAR: begin
                table_valid = '0;
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    task automatic issue_job(input job_item_t it, input logic known, input job_result_t typed);
        int gap;
        job_result_t predicted;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid           <= 1'b1;
        s_func            <= it.func;
        s_now             <= it.now;
        s_delay_ms        <= it.delay_ms;
        s_has_alternative <= it.has_alt;
        s_alt_flags       <= it.alt_flags;
        do @(posedge aclk); while (!s_ready);
        predicted = predict_job(it);
        pending_results.push_back(known ? typed : predicted);
    endtask

    task automatic random_job();
        job_item_t   it;
        int unsigned pick;
        int unsigned span;
        pick         = $urandom_range(0, 99);
        span         = 32'd3 * ticks_setting + 32'd50;
        it.func      = FUNC_SCHEDULE;
        it.delay_ms  = $urandom_range(0, 6);
        it.has_alt   = 1'($urandom);
        it.alt_flags = 16'($urandom);
        if (pick < 2) begin
            cur_time = 32'hFFFF_FFFF - $urandom_range(0, span);
        end
        if (pick < 45) begin
            it.now = cur_time;
        end else if (pick < 85) begin
            cur_time = cur_time + $urandom_range(0, span);
            it.func  = FUNC_RUN;
            it.now   = cur_time;
        end else if (pick < 89) begin
            it.func = FUNC_CLEAR;
            it.now  = cur_time;
        end else if (pick < 92) begin
            it.func = FUNC_UNUSED;
            it.now  = $urandom;
        end else begin
            it.func     = 2'($urandom);
            it.now      = $urandom;
            it.delay_ms = $urandom;
        end
        issue_job(it, 1'b0, '0);
    endtask

    task automatic write_ticks(input logic [31:0] value);
        logic [31:0] readback;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_TICKS;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        ticks_setting = value[TICKS_W-1:0];
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        readback = prdata;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback !== {{(32 - TICKS_W){1'b0}}, ticks_setting}) begin
            $error("ticks_per_ms: expected %0d, actual %0d", ticks_setting, readback);
            mismatches++;
        end
    endtask

    task automatic settle();
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic check_result();
        job_result_t want;
        if (pending_results.size() == 0) begin
            $error("result with no item outstanding: granted=%0d slot=%0d fired=%h alt=%h",
                   m_granted, m_slot, m_fired_mask, m_alt_mask);
            mismatches++;
        end else begin
            want = pending_results.pop_front();
            if (m_granted !== want.granted) begin
                $error("granted: expected %0d, actual %0d", want.granted, m_granted);
                mismatches++;
            end
            if (m_slot !== want.slot) begin
                $error("slot: expected %0d, actual %0d", want.slot, m_slot);
                mismatches++;
            end
            if (m_fired_mask !== want.fired) begin
                $error("fired_mask: expected %h, actual %h", want.fired, m_fired_mask);
                mismatches++;
            end
            if (m_alt_mask !== want.alt) begin
                $error("alt_mask: expected %h, actual %h", want.alt, m_alt_mask);
                mismatches++;
            end
        end
    endtask

    initial begin
        int stall;
        m_ready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 4);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            check_result();
        end
    end

    initial begin
        job_item_t   it;
        job_result_t typed;
        logic [31:0] phase_ticks [RANDOM_PHASES];
        aresetn           <= 1'b0;
        s_valid           <= 1'b0;
        s_func            <= FUNC_SCHEDULE;
        s_now             <= '0;
        s_delay_ms        <= '0;
        s_has_alternative <= 1'b0;
        s_alt_flags       <= '0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= ADDR_TICKS;
        pwdata            <= '0;
        ticks_setting = TICKS_RESET;
        table_valid   = '0;
        no_idle       = 1'b0;
        cur_time      = $urandom;
        phase_ticks[0] = 32'd1;
        phase_ticks[1] = {12'($urandom), 20'hFFFFF};
        phase_ticks[2] = 32'd0;
        phase_ticks[3] = {12'($urandom), 20'($urandom_range(1, 20'hFFFFF))};
        phase_ticks[4] = {12'd0, TICKS_RESET};
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_table[r]) begin
            it    = '{dir_table[r].func, dir_table[r].now, dir_table[r].delay_ms,
                      dir_table[r].has_alt, dir_table[r].alt_flags};
            typed = '{dir_table[r].granted, dir_table[r].slot, dir_table[r].fired,
                      dir_table[r].alt};
            repeat (dir_table[r].reps) issue_job(it, dir_table[r].known, typed);
        end

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            s_valid <= 1'b0;
            settle();
            write_ticks(phase_ticks[p]);
            no_idle = (p == 2);
            repeat (ITEMS_PER_PHASE) random_job();
        end
        s_valid <= 1'b0;
        settle();

        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
